>>> hdl/bb3_pkg.sv
// Package for the 3x3 box blur: sizes, config register codes, pixel and
// pipeline control types shared by all block files.
// No dependencies.
package bb3_pkg;

  // Frame limits
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  // Counter and index widths derived from the limits
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int OWED_W = $clog2(MAX_WIDTH + 2);

  // Channel arithmetic
  localparam int CH_W     = 8;
  localparam int COLSUM_W = 10;
  localparam int SUM_W    = 12;
  localparam int ROUND    = 4;
  // Divide by nine as a multiply by a scaled reciprocal (exact for sums below 32768)
  localparam int RECIP_SH = 15;
  localparam int RECIP    = (2**RECIP_SH + 8) / 9;
  localparam int RECIP_W  = 12;
  localparam int PROD_W   = SUM_W + RECIP_W;

  // Configuration port
  localparam int CFG_WIDTH_W  = 12;
  localparam int CFG_HEIGHT_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
  localparam logic [CFG_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 12'd640;
  localparam logic [CFG_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // Output queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  // Where a result is taken from
  typedef enum logic [2:0] {
    SRC_MEAN,
    SRC_UPPER_B,
    SRC_LEFT,
    SRC_HOLD,
    SRC_MIDDLE_B
  } res_src_t;

  // Line store access issued when a request is accepted
  typedef struct packed {
    logic             rd_en;
    logic             middle_we;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] upper_b_addr;
    logic [COL_W-1:0] middle_b_addr;
  } mem_req_t;

  // Control of one request in the read-data stage
  typedef struct packed {
    logic             pix;
    logic             res;
    res_src_t         src;
    logic             fe;
    logic [COL_W-1:0] col;
    logic             upper_we;
    logic             hold_set;
    logic             row_ge1;
    logic             row_ge2;
  } step_t;

endpackage

>>> hdl/bb3_in_if.sv
// Input channel of the box blur: valid/ready handshake with one pixel or flush request.
// Depends on bb3_pkg.
interface bb3_in_if import bb3_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            kind;
  logic [CH_W-1:0] in_blue;
  logic [CH_W-1:0] in_green;
  logic [CH_W-1:0] in_red;

  modport source (output valid, kind, in_blue, in_green, in_red, input ready);
  modport sink   (input valid, kind, in_blue, in_green, in_red, output ready);
endinterface

>>> hdl/bb3_out_if.sv
// Output channel of the box blur: valid/ready handshake with one result pixel.
// Depends on bb3_pkg.
interface bb3_out_if import bb3_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_blue;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_red;
  logic            frame_end;

  modport source (output valid, out_blue, out_green, out_red, frame_end, input ready);
  modport sink   (input valid, out_blue, out_green, out_red, frame_end, output ready);
endinterface

>>> hdl/bb3_ctrl.sv
// Raster position, frame size latch and owed-result tracking of the box blur.
// Issues line store accesses per accepted request. Depends on bb3_pkg.
module bb3_ctrl import bb3_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  acc,
  input  logic                  kind,
  input  pix_t                  px,
  output mem_req_t              req,
  output step_t                 b,
  output pix_t                  b_px
);

  function automatic logic [WID_W-1:0] clamp_w(input logic [CFG_WIDTH_W-1:0] v);
    logic [WID_W-1:0] r;
    if (v == '0) r = WID_W'(1);
    else if (int'(v) > MAX_WIDTH) r = WID_W'(MAX_WIDTH);
    else r = WID_W'(v);
    return r;
  endfunction

  function automatic logic [HGT_W-1:0] clamp_h(input logic [CFG_HEIGHT_W-1:0] v);
    logic [HGT_W-1:0] r;
    if (v == '0) r = HGT_W'(1);
    else if (int'(v) > MAX_HEIGHT) r = HGT_W'(MAX_HEIGHT);
    else r = HGT_W'(v);
    return r;
  endfunction

  logic [CFG_WIDTH_W-1:0]  frame_width;
  logic [CFG_HEIGHT_W-1:0] frame_height;

  logic [COL_W-1:0]  in_column, in_column_next;
  logic [ROW_W-1:0]  in_row, in_row_next;
  logic [WID_W-1:0]  cur_w, cur_w_next;
  logic [HGT_W-1:0]  cur_h, cur_h_next;
  logic [OWED_W-1:0] owed, owed_next;
  logic [WID_W-1:0]  tail_w, tail_w_next;
  logic [WID_W-1:0]  tail_col, tail_col_next;
  logic              tail_upper, tail_upper_next;
  logic              hold_ok, hold_ok_next;

  logic              pixel, start, own, take;
  logic [WID_W-1:0]  w_eff, col_inc, w_last, tw_last;
  logic [HGT_W-1:0]  h_eff, row_inc;
  step_t             step;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[CFG_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Work out the position, result source and tail update of this request
  always_comb begin
    pixel = !kind;
    start = pixel && (in_row == '0) && (in_column == '0);
    w_eff = start ? clamp_w(frame_width) : cur_w;
    h_eff = start ? clamp_h(frame_height) : cur_h;
    w_last  = w_eff - WID_W'(1);
    tw_last = tail_w - WID_W'(1);
    own   = pixel && ((in_row >= ROW_W'(2)) || ((in_row == ROW_W'(1)) && (in_column != '0)));
    take  = !own && (owed != '0);

    in_column_next  = in_column;
    in_row_next     = in_row;
    cur_w_next      = cur_w;
    cur_h_next      = cur_h;
    owed_next       = owed;
    tail_w_next     = tail_w;
    tail_col_next   = tail_col;
    tail_upper_next = tail_upper;
    hold_ok_next    = hold_ok;
    col_inc         = WID_W'(in_column) + WID_W'(1);
    row_inc         = HGT_W'(in_row) + HGT_W'(1);

    step          = '0;
    step.pix      = pixel;
    step.col      = in_column;
    step.upper_we = pixel && (in_row != '0);
    step.row_ge1  = in_row != '0;
    step.row_ge2  = in_row >= ROW_W'(2);
    step.src      = SRC_MIDDLE_B;

    req.rd_en         = acc;
    req.middle_we     = acc && pixel;
    req.col           = in_column;
    req.upper_b_addr  = tw_last[COL_W-1:0];
    req.middle_b_addr = tail_col[COL_W-1:0];

    if (own) begin
      // Own result: drop whatever older results are still owed
      step.res        = 1'b1;
      owed_next       = '0;
      tail_upper_next = 1'b0;
      hold_ok_next    = 1'b0;
      if ((in_row >= ROW_W'(2)) && (in_column >= COL_W'(2))) begin
        step.src = SRC_MEAN;
      end else if (in_column == '0) begin
        step.src         = SRC_UPPER_B;
        req.upper_b_addr = w_last[COL_W-1:0];
      end else begin
        step.src = SRC_LEFT;
      end
    end else if (take) begin
      // Release the next owed result of the previous frame
      step.res  = 1'b1;
      step.fe   = owed == OWED_W'(1);
      owed_next = owed - OWED_W'(1);
      if (tail_upper) begin
        step.src        = SRC_UPPER_B;
        tail_upper_next = 1'b0;
      end else if (hold_ok) begin
        step.src      = SRC_HOLD;
        hold_ok_next  = 1'b0;
        tail_col_next = tail_col + WID_W'(1);
      end else begin
        step.src      = SRC_MIDDLE_B;
        tail_col_next = tail_col + WID_W'(1);
      end
    end

    // Keep an owed entry that this pixel's write is about to overwrite
    step.hold_set = pixel && (owed_next != '0) && !tail_upper_next && !hold_ok_next &&
                    (tail_col_next == WID_W'(in_column));
    if (step.hold_set) hold_ok_next = 1'b1;

    // Advance the raster position and arm the tail at frame end
    if (pixel) begin
      if (start) begin
        cur_w_next = w_eff;
        cur_h_next = h_eff;
      end
      if (col_inc >= w_eff) begin
        in_column_next = '0;
        if (row_inc >= h_eff) begin
          in_row_next     = '0;
          tail_upper_next = h_eff >= HGT_W'(2);
          owed_next       = tail_upper_next ? OWED_W'(w_eff) + OWED_W'(1) : OWED_W'(w_eff);
          tail_w_next     = w_eff;
          tail_col_next   = '0;
          hold_ok_next    = 1'b0;
        end else begin
          in_row_next = row_inc[ROW_W-1:0];
        end
      end else begin
        in_column_next = col_inc[COL_W-1:0];
      end
    end
  end

  // Update state on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      cur_w      <= WID_W'(1);
      cur_h      <= HGT_W'(1);
      owed       <= '0;
      tail_w     <= WID_W'(1);
      tail_col   <= '0;
      tail_upper <= 1'b0;
      hold_ok    <= 1'b0;
      b          <= '0;
    end else begin
      b <= acc ? step : '0;
      if (acc) begin
        in_column  <= in_column_next;
        in_row     <= in_row_next;
        cur_w      <= cur_w_next;
        cur_h      <= cur_h_next;
        owed       <= owed_next;
        tail_w     <= tail_w_next;
        tail_col   <= tail_col_next;
        tail_upper <= tail_upper_next;
        hold_ok    <= hold_ok_next;
      end
    end
  end

  // Hold the incoming pixel for the read-data stage
  always_ff @(posedge clk) begin
    if (acc) b_px <= px;
  end

endmodule

>>> hdl/bb3_lines.sv
// Two line stores of the box blur with registered reads, forwarding of the
// late upper-line write and the one-pixel hold register. Depends on bb3_pkg.
module bb3_lines import bb3_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mem_req_t req,
  input  pix_t     px,
  input  step_t    b,
  output pix_t     mid_raw,
  output pix_t     up_a,
  output pix_t     up_b,
  output pix_t     mid_b,
  output pix_t     hold_px
);

  pix_t upper_mem  [MAX_WIDTH];
  pix_t middle_mem [MAX_WIDTH];

  pix_t up_a_q, up_b_q, fwd_data;
  logic fwd_a, fwd_b;

  // Read both stores on accept; read before write at the same address
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      mid_raw  <= middle_mem[req.col];
      mid_b    <= middle_mem[req.middle_b_addr];
      up_a_q   <= upper_mem[req.col];
      up_b_q   <= upper_mem[req.upper_b_addr];
      fwd_data <= mid_raw;
    end
    if (req.middle_we) middle_mem[req.col] <= px;
    if (b.upper_we) upper_mem[b.col] <= mid_raw;
    if (b.hold_set) hold_px <= mid_raw;
  end

  // Flag reads that meet the upper write landing on the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_a <= 1'b0;
      fwd_b <= 1'b0;
    end else if (req.rd_en) begin
      fwd_a <= b.upper_we && (b.col == req.col);
      fwd_b <= b.upper_we && (b.col == req.upper_b_addr);
    end
  end

  assign up_a = fwd_a ? fwd_data : up_a_q;
  assign up_b = fwd_b ? fwd_data : up_b_q;

endmodule

>>> hdl/bb3_lane.sv
// One colour channel lane of the box blur: column sums, window of three
// columns and the rounded divide by nine. Depends on bb3_pkg.
module bb3_lane import bb3_pkg::*; (
  input  logic            clk,
  input  logic            shift,
  input  logic            row_ge1,
  input  logic            row_ge2,
  input  logic [CH_W-1:0] up_raw,
  input  logic [CH_W-1:0] mid_raw,
  input  logic [CH_W-1:0] px,
  output logic [CH_W-1:0] left,
  output logic [CH_W-1:0] mean
);

  logic [CH_W-1:0]     up, mid, mid_last;
  logic [COLSUM_W-1:0] col_sum, win_old, win_new;
  logic [SUM_W-1:0]    sum, sum_q;
  logic [PROD_W-1:0]   prod;

  // Form this column and the rounded window sum
  always_comb begin
    up      = row_ge2 ? up_raw : '0;
    mid     = row_ge1 ? mid_raw : '0;
    col_sum = COLSUM_W'(up) + COLSUM_W'(mid) + COLSUM_W'(px);
    sum     = SUM_W'(win_old) + SUM_W'(win_new) + SUM_W'(col_sum) + SUM_W'(ROUND);
    left    = mid_last;
  end

  // Shift the window on pixel requests; register the sum for the divide
  always_ff @(posedge clk) begin
    if (shift) begin
      win_old  <= win_new;
      win_new  <= col_sum;
      mid_last <= mid;
    end
    sum_q <= sum;
  end

  // Divide by nine through the reciprocal
  assign prod = PROD_W'(sum_q) * PROD_W'(RECIP);
  assign mean = prod[RECIP_SH +: CH_W];

endmodule

>>> hdl/bb3_merge.sv
// Result merge of the box blur: picks the lane means or a passed pixel and
// queues results for the output channel. Depends on bb3_pkg, bb3_out_if.
module bb3_merge import bb3_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  step_t b,
  input  pix_t  left,
  input  pix_t  up_b,
  input  pix_t  hold_px,
  input  pix_t  mid_b,
  input  pix_t  mean,
  output logic  room,
  bb3_out_if.source pix_out
);

  typedef struct packed {
    pix_t pix;
    logic fe;
  } out_t;

  out_t                queue [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [OQ_CNT_W-1:0] count;
  logic [OQ_CNT_W:0]   load;

  logic c_res, c_mean, c_fe;
  pix_t c_pass, pass;
  logic push, pop;

  // Select the passed pixel for this request
  always_comb begin
    case (b.src)
      SRC_UPPER_B:  pass = up_b;
      SRC_LEFT:     pass = left;
      SRC_HOLD:     pass = hold_px;
      SRC_MIDDLE_B: pass = mid_b;
      default:      pass = '0;
    endcase
  end

  // Advance into the divide stage
  always_ff @(posedge clk) begin
    if (rst) c_res <= 1'b0;
    else     c_res <= b.res;
  end

  always_ff @(posedge clk) begin
    c_mean <= b.src == SRC_MEAN;
    c_fe   <= b.fe;
    c_pass <= pass;
  end

  assign push = c_res;
  assign pop  = pix_out.valid && pix_out.ready;

  // Queue results
  always_ff @(posedge clk) begin
    if (push) queue[wr_ptr] <= '{pix: c_mean ? mean : c_pass, fe: c_fe};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + OQ_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + OQ_PTR_W'(1);
      count <= count + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
    end
  end

  // Accept only while every result in flight has a queue slot
  assign load = (OQ_CNT_W+1)'(count) + (OQ_CNT_W+1)'(b.res) + (OQ_CNT_W+1)'(c_res);
  assign room = load < (OQ_CNT_W+1)'(OQ_DEPTH);

  assign pix_out.valid     = count != '0;
  assign pix_out.out_red   = queue[rd_ptr].pix.red;
  assign pix_out.out_green = queue[rd_ptr].pix.green;
  assign pix_out.out_blue  = queue[rd_ptr].pix.blue;
  assign pix_out.frame_end = queue[rd_ptr].fe;

endmodule

>>> hdl/box_blur_3x3_rgb.sv
// 3x3 box mean filter for a raster stream of RGB pixels.
// Depends on bb3_pkg, bb3_in_if, bb3_out_if, bb3_ctrl, bb3_lines, bb3_lane, bb3_merge.
//
// Usage
//   pix_in carries pixel requests (kind 0) in raster order, or flush requests
//   (kind 1) that release one owed result each. pix_out carries results in
//   raster order; frame_end marks the last released pixel of a frame.
//   Interior pixels become (sum of the 3x3 neighbourhood + 4) / 9 per
//   channel; border pixels pass through. frame_width and frame_height are
//   written on the cfg port and take effect at the next frame start.
// Timing
//   One request per cycle unless pix_out stalls. A result is registered in the
//   read-data and divide stages and queued before pix_out offers it; in pixels
//   the output runs frame_width + 1 requests behind the input. The rate is set by
//   the line stores, each read at two addresses and written once per cycle.
// Reset and stalls
//   Reset clears position, owed count and queue, loads 640 x 480 and holds
//   pix_in.ready low. The line stores are not cleared: each entry is read only
//   after a write. When pix_out stalls, the four-entry output queue fills and
//   pix_in.ready drops until a slot frees up; nothing is lost.
module box_blur_3x3_rgb import bb3_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bb3_in_if.sink                pix_in,
  bb3_out_if.source             pix_out
);

  logic     acc, room;
  pix_t     in_px, b_px;
  mem_req_t req;
  step_t    b;
  pix_t     mid_raw, up_a, up_b, mid_b, hold_px, left, mean;
  logic [CH_W-1:0] left_r, left_g, left_b, mean_r, mean_g, mean_b;

  // Take a request when the output side has room and reset is released
  assign pix_in.ready = room && !rst;
  assign acc          = pix_in.valid && pix_in.ready;
  assign in_px        = '{red: pix_in.in_red, green: pix_in.in_green, blue: pix_in.in_blue};

  bb3_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .kind      (pix_in.kind),
    .px        (in_px),
    .req       (req),
    .b         (b),
    .b_px      (b_px)
  );

  bb3_lines u_lines (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .px      (in_px),
    .b       (b),
    .mid_raw (mid_raw),
    .up_a    (up_a),
    .up_b    (up_b),
    .mid_b   (mid_b),
    .hold_px (hold_px)
  );

  bb3_lane u_lane_red (
    .clk     (clk),
    .shift   (b.pix),
    .row_ge1 (b.row_ge1),
    .row_ge2 (b.row_ge2),
    .up_raw  (up_a.red),
    .mid_raw (mid_raw.red),
    .px      (b_px.red),
    .left    (left_r),
    .mean    (mean_r)
  );

  bb3_lane u_lane_green (
    .clk     (clk),
    .shift   (b.pix),
    .row_ge1 (b.row_ge1),
    .row_ge2 (b.row_ge2),
    .up_raw  (up_a.green),
    .mid_raw (mid_raw.green),
    .px      (b_px.green),
    .left    (left_g),
    .mean    (mean_g)
  );

  bb3_lane u_lane_blue (
    .clk     (clk),
    .shift   (b.pix),
    .row_ge1 (b.row_ge1),
    .row_ge2 (b.row_ge2),
    .up_raw  (up_a.blue),
    .mid_raw (mid_raw.blue),
    .px      (b_px.blue),
    .left    (left_b),
    .mean    (mean_b)
  );

  // Gather the lane outputs into pixels
  assign left = '{red: left_r, green: left_g, blue: left_b};
  assign mean = '{red: mean_r, green: mean_g, blue: mean_b};

  bb3_merge u_merge (
    .clk     (clk),
    .rst     (rst),
    .b       (b),
    .left    (left),
    .up_b    (up_b),
    .hold_px (hold_px),
    .mid_b   (mid_b),
    .mean    (mean),
    .room    (room),
    .pix_out (pix_out)
  );

endmodule
